@@ rtl/edlr_pkg.sv @@
// ----------------------------------------------------------------------------
// edlr_pkg
// Types, register codes and constant tables shared by the schedule unit.
// ----------------------------------------------------------------------------
package edlr_pkg;

    localparam int FRAC_BITS = 28;
    localparam int LOG_W     = 33;             // Q5.28 log2 value
    localparam int DIV_STEPS = 64;             // one quotient bit per cycle
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [31:0] MAX_RATE = 32'hFFFF_FFFF;
    localparam logic [16:0] ONE_Q16  = 17'd65536;

    localparam logic [16:0] DELAY_MULT_RST   = 17'd65536;
    localparam logic [23:0] DECAY_STEPS_RST  = 24'd30000;
    localparam logic [23:0] SPIKE_PERIOD_RST = 24'd100;

    typedef enum logic [2:0] {
        CFG_DELAY_MULT     = 3'd0,
        CFG_DELAY_STEPS    = 3'd1,
        CFG_DECAY_STEPS    = 3'd2,
        CFG_SPIKE_START    = 3'd3,
        CFG_SPIKE_END      = 3'd4,
        CFG_SPIKE_PERIOD   = 3'd5,
        CFG_SPIKE_LEN      = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [16:0] delay_mult;
        logic [23:0] delay_steps;
        logic [23:0] decay_steps;
        logic [23:0] spike_start;
        logic [23:0] spike_end;
        logic [23:0] spike_period;
        logic [23:0] spike_len;
    } t_cfg;

    // one classified item as it waits between front and back
    typedef struct packed {
        logic [23:0] iteration;
        logic [31:0] start_rate;
        logic [31:0] final_rate;
        logic        decay_done;
        logic        s_zero;
        logic        it_zero;
        logic        f_zero;
        logic        warm;
        logic        spike_win;
        logic        period_zero;
    } t_item;

    typedef enum logic [4:0] {
        BS_IDLE,
        BS_LOG_INIT,
        BS_LOG_STEP,
        BS_DIFF,
        BS_DEC_MUL,
        BS_DEC_DIV,
        BS_POW,
        BS_POW_FIN,
        BS_WARM_MUL,
        BS_WARM_DIV,
        BS_WARM_SCALE,
        BS_SPK_MOD,
        BS_SPK_REM,
        BS_SPK_CHK,
        BS_SPK_MUL,
        BS_SPK_DIV,
        BS_OUT
    } t_bstate;

    typedef logic [FRAC_BITS:0][32:0] t_root_tab;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        for (int i = 0; i < 32; i++) begin
            b = 64'd1 << (62 - 2 * i);
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    // 2^(2^-k) in Q2.31, each root taken from the one before
    function automatic t_root_tab gen_roots();
        t_root_tab   tab;
        logic [63:0] sq;
        tab[0] = 33'h1_0000_0000;
        for (int k = 1; k <= FRAC_BITS; k++) begin
            sq     = isqrt64({tab[k-1], 31'd0});
            tab[k] = sq[32:0];
        end
        return tab;
    endfunction

    localparam t_root_tab ROOTS = gen_roots();

endpackage

@@ rtl/edlr_div.sv @@
// ----------------------------------------------------------------------------
// edlr_div
// Restoring divider, 64-bit dividend by 24-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module edlr_div import edlr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [23:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quot,
    output logic [23:0] o_rem
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [63:0]          r_quot;
    logic [23:0]          r_rem;
    logic [23:0]          r_div;

    logic [24:0] trial;
    logic [24:0] diff;
    logic        ge;

    assign trial = {r_rem, r_quot[63]};
    assign diff  = trial - {1'b0, r_div};
    assign ge    = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[23:0] : trial[23:0];
            r_quot <= {r_quot[62:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

@@ rtl/edlr_front.sv @@
// ----------------------------------------------------------------------------
// edlr_front
// Takes input words and tags each with the path it will follow.
// ----------------------------------------------------------------------------
module edlr_front import edlr_pkg::*; (
    input  logic        i_tvalid,
    output logic        o_tready,
    input  logic [87:0] i_tdata,    // iteration[23:0], start_rate[55:24], final_rate[87:56]
    input  logic        i_tuser,    // spike_on
    input  t_cfg        i_cfg,
    input  logic        i_q_full,
    output logic        o_push,
    output t_item       o_item
);

    logic [23:0] it;

    assign it       = i_tdata[23:0];
    assign o_tready = !i_q_full;
    assign o_push   = i_tvalid && !i_q_full;

    always_comb begin
        o_item.iteration   = it;
        o_item.start_rate  = i_tdata[55:24];
        o_item.final_rate  = i_tdata[87:56];
        o_item.decay_done  = it >= i_cfg.decay_steps;
        o_item.s_zero      = i_tdata[55:24] == '0;
        o_item.it_zero     = it == '0;
        o_item.f_zero      = i_tdata[87:56] == '0;
        o_item.warm        = (i_cfg.delay_steps != '0) && (it < i_cfg.delay_steps);
        o_item.spike_win   = i_tuser && (it >= i_cfg.spike_start) && (it < i_cfg.spike_end);
        o_item.period_zero = i_cfg.spike_period == '0;
    end

endmodule

@@ rtl/edlr_queue.sv @@
// ----------------------------------------------------------------------------
// edlr_queue
// Small FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module edlr_queue import edlr_pkg::*; #(
    parameter  int DEPTH = 4,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_item            i_item,
    input  logic             i_pop,
    output t_item            o_head,
    output logic             o_empty,
    output logic             o_full,
    output logic [CNT_W-1:0] o_count
);

    localparam int PTR_W = $clog2(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_empty = r_count == '0;
    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_count = r_count;

endmodule

@@ rtl/edlr_back.sv @@
// ----------------------------------------------------------------------------
// edlr_back
// Sequencer computing one rate: log2, scaled exponent, exp2, warm-up, spike.
// Shares one multiplier and one serial divider; result held in an out register.
// ----------------------------------------------------------------------------
module edlr_back import edlr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_empty,
    input  t_item       i_q_head,
    output logic        o_q_pop,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [31:0] o_tdata     // rate
);

    t_bstate r_state, n_state;

    t_item       r_item;
    logic [31:0] r_m;
    logic [4:0]  r_top;
    logic [27:0] r_frac;
    logic [4:0]  r_cnt;
    logic        r_lsel;
    logic [32:0] r_ls, r_lf, r_mag, r_t, r_acc;
    logic        r_neg;
    logic [31:0] r_base;
    logic [16:0] r_fac;
    logic [23:0] r_off;
    logic [56:0] r_pa;
    logic        r_out_valid;
    logic [31:0] r_out_rate;

    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic [64:0] mul_p;

    logic        div_start;
    logic [63:0] div_dividend;
    logic [23:0] div_divisor;
    logic        div_done;
    logic [63:0] div_quot;
    logic [23:0] div_rem;

    logic        out_load;

    logic [31:0] log_x;
    logic [4:0]  log_top;
    logic [32:0] sq_p;
    logic [16:0] wmag;
    logic        wneg;
    logic [33:0] tsum;
    logic [4:0]  bidx;
    logic [32:0] pow_v;
    logic [32:0] warm_v;
    logic [57:0] spk_sum;
    logic [17:0] fac_sum;

    function automatic logic [4:0] msb_idx(input logic [31:0] x);
        logic [4:0] idx;
        idx = '0;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

    edlr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign mul_p   = mul_a * mul_b;
    assign log_x   = r_lsel ? r_item.final_rate : r_item.start_rate;
    assign log_top = msb_idx(log_x);
    assign sq_p    = mul_p[63:31];
    assign wneg    = i_cfg.delay_mult > ONE_Q16;
    assign wmag    = wneg ? i_cfg.delay_mult - ONE_Q16 : ONE_Q16 - i_cfg.delay_mult;
    assign tsum    = {1'b0, r_ls} + {1'b0, div_quot[32:0]};
    assign bidx    = 5'(FRAC_BITS) - r_cnt;
    assign pow_v   = r_acc >> (5'd31 - r_t[32:28]);
    assign warm_v  = mul_p[48:16];
    assign spk_sum = {1'b0, r_pa} + {1'b0, mul_p[56:0]};
    assign fac_sum = r_neg ? {1'b0, i_cfg.delay_mult} - {1'b0, div_quot[16:0]}
                           : {1'b0, i_cfg.delay_mult} + {1'b0, div_quot[16:0]};
    assign out_load = (r_state == BS_OUT) && (!r_out_valid || i_tready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_IDLE: begin
                if (!i_q_empty) begin
                    if (i_q_head.decay_done || i_q_head.s_zero) begin
                        n_state = BS_SPK_MOD;
                    end else if (i_q_head.it_zero || i_q_head.f_zero) begin
                        n_state = BS_WARM_MUL;
                    end else begin
                        n_state = BS_LOG_INIT;
                    end
                end
            end
            BS_LOG_INIT: n_state = BS_LOG_STEP;
            BS_LOG_STEP: begin
                if (r_cnt == 5'(FRAC_BITS - 1)) begin
                    n_state = r_lsel ? BS_DIFF : BS_LOG_INIT;
                end
            end
            BS_DIFF:    n_state = BS_DEC_MUL;
            BS_DEC_MUL: n_state = BS_DEC_DIV;
            BS_DEC_DIV: begin
                if (div_done) n_state = BS_POW;
            end
            BS_POW: begin
                if (r_cnt == 5'(FRAC_BITS)) n_state = BS_POW_FIN;
            end
            BS_POW_FIN:  n_state = BS_WARM_MUL;
            BS_WARM_MUL: n_state = r_item.warm ? BS_WARM_DIV : BS_SPK_MOD;
            BS_WARM_DIV: begin
                if (div_done) n_state = BS_WARM_SCALE;
            end
            BS_WARM_SCALE: n_state = BS_SPK_MOD;
            BS_SPK_MOD: begin
                if (!r_item.spike_win) begin
                    n_state = BS_OUT;
                end else if (r_item.period_zero) begin
                    n_state = BS_SPK_CHK;
                end else begin
                    n_state = BS_SPK_REM;
                end
            end
            BS_SPK_REM: begin
                if (div_done) n_state = BS_SPK_CHK;
            end
            BS_SPK_CHK: n_state = (r_off < i_cfg.spike_len) ? BS_SPK_MUL : BS_OUT;
            BS_SPK_MUL: n_state = BS_SPK_DIV;
            BS_SPK_DIV: begin
                if (div_done) n_state = BS_OUT;
            end
            BS_OUT: begin
                if (out_load) n_state = BS_IDLE;
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // unit control and operand selection
    always_comb begin
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        o_q_pop      = 1'b0;
        case (r_state)
            BS_IDLE: o_q_pop = !i_q_empty;
            BS_LOG_STEP: begin
                mul_a = {1'b0, r_m};
                mul_b = r_m;
            end
            BS_DEC_MUL: begin
                mul_a        = r_mag;
                mul_b        = {8'd0, r_item.iteration};
                div_start    = 1'b1;
                div_dividend = mul_p[63:0];
                div_divisor  = i_cfg.decay_steps;
            end
            BS_POW: begin
                mul_a = r_acc;
                mul_b = ROOTS[r_cnt][31:0];
            end
            BS_WARM_MUL: begin
                mul_a        = {16'd0, wmag};
                mul_b        = {8'd0, r_item.iteration};
                div_start    = r_item.warm;
                div_dividend = mul_p[63:0];
                div_divisor  = i_cfg.delay_steps;
            end
            BS_WARM_SCALE: begin
                mul_a = {1'b0, r_base};
                mul_b = {15'd0, r_fac};
            end
            BS_SPK_MOD: begin
                div_start    = r_item.spike_win && !r_item.period_zero;
                div_dividend = {40'd0, r_item.iteration};
                div_divisor  = i_cfg.spike_period;
            end
            BS_SPK_CHK: begin
                mul_a = {1'b0, r_item.start_rate};
                mul_b = {8'd0, i_cfg.spike_len - r_off};
            end
            BS_SPK_MUL: begin
                mul_a        = {1'b0, r_base};
                mul_b        = {8'd0, r_off};
                div_start    = 1'b1;
                div_dividend = {6'd0, spk_sum};
                div_divisor  = i_cfg.spike_len;
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BS_IDLE: begin
                r_item <= i_q_head;
                r_lsel <= 1'b0;
                if (i_q_head.decay_done) begin
                    r_base <= i_q_head.final_rate;
                end else if (i_q_head.it_zero && !i_q_head.s_zero) begin
                    r_base <= i_q_head.start_rate;
                end else begin
                    r_base <= '0;
                end
            end
            BS_LOG_INIT: begin
                r_m    <= log_x << (5'd31 - log_top);
                r_top  <= log_top;
                r_frac <= '0;
                r_cnt  <= '0;
            end
            BS_LOG_STEP: begin
                // mantissa reaching two yields a one bit and is halved
                r_m    <= sq_p[32] ? sq_p[32:1] : sq_p[31:0];
                r_frac <= {r_frac[26:0], sq_p[32]};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == 5'(FRAC_BITS - 1)) begin
                    if (r_lsel) begin
                        r_lf <= {r_top, r_frac[26:0], sq_p[32]};
                    end else begin
                        r_ls <= {r_top, r_frac[26:0], sq_p[32]};
                    end
                    r_lsel <= 1'b1;
                end
            end
            BS_DIFF: begin
                r_neg <= r_lf < r_ls;
                r_mag <= (r_lf < r_ls) ? r_ls - r_lf : r_lf - r_ls;
            end
            BS_DEC_DIV: begin
                if (r_neg) begin
                    r_t <= (div_quot > {31'd0, r_ls}) ? '0 : r_ls - div_quot[32:0];
                end else begin
                    r_t <= tsum[33] ? {LOG_W{1'b1}} : tsum[32:0];
                end
                r_acc <= 33'h0_8000_0000;
                r_cnt <= 5'd1;
            end
            BS_POW: begin
                if (r_t[bidx]) begin
                    r_acc <= mul_p[63:31];
                end
                r_cnt <= r_cnt + 1'b1;
            end
            BS_POW_FIN: r_base <= pow_v[32] ? MAX_RATE : pow_v[31:0];
            BS_WARM_MUL: r_neg <= wneg;
            BS_WARM_DIV: begin
                if (div_done) r_fac <= fac_sum[16:0];
            end
            BS_WARM_SCALE: r_base <= warm_v[32] ? MAX_RATE : warm_v[31:0];
            BS_SPK_MOD: begin
                if (r_item.period_zero) r_off <= r_item.iteration;
            end
            BS_SPK_REM: begin
                if (div_done) r_off <= div_rem;
            end
            BS_SPK_CHK: r_pa <= mul_p[56:0];
            BS_SPK_DIV: begin
                if (div_done) r_base <= (div_quot[63:32] != '0) ? MAX_RATE : div_quot[31:0];
            end
            BS_OUT: begin
                if (out_load) r_out_rate <= r_base;
            end
            default: begin
                r_off <= r_off;
            end
        endcase
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_rate;

endmodule

@@ rtl/exp_decay_lr_schedule_with_spikes_unit.sv @@
// ----------------------------------------------------------------------------
// exp_decay_lr_schedule_with_spikes_unit
// Path: a word that has reached decay_steps, outside a spike window, passes BS_IDLE,
//   BS_SPK_MOD and BS_OUT; the longest path adds log2, exponent division, warm-up, spike.
// Pace: one word at a time in the back end; the 28-step log2 squaring loop (twice),
//   the 28-step exp2 loop and the serial divides set how long each word takes.
// The input queue takes up to QUEUE_DEPTH words while the back end is busy.
// Reset: registers to their defaults, queue and output empty; no clear pass.
// ----------------------------------------------------------------------------
module exp_decay_lr_schedule_with_spikes_unit import edlr_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [87:0] i_s_axis_tdata,   // iteration[23:0], start_rate[55:24], final_rate[87:56]
    input  logic        i_s_axis_tuser,   // spike_on
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // rate
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cfg             r_cfg;
    logic             q_push;
    logic             q_pop;
    logic             q_empty;
    logic             q_full;
    logic [CNT_W-1:0] q_count;
    t_item            f_item;
    t_item            q_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delay_mult     <= DELAY_MULT_RST;
            r_cfg.delay_steps    <= '0;
            r_cfg.decay_steps    <= DECAY_STEPS_RST;
            r_cfg.spike_start    <= '0;
            r_cfg.spike_end      <= '0;
            r_cfg.spike_period   <= SPIKE_PERIOD_RST;
            r_cfg.spike_len      <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DELAY_MULT:     r_cfg.delay_mult     <= i_cfg_data[16:0];
                CFG_DELAY_STEPS:    r_cfg.delay_steps    <= i_cfg_data;
                CFG_DECAY_STEPS:    r_cfg.decay_steps    <= i_cfg_data;
                CFG_SPIKE_START:    r_cfg.spike_start    <= i_cfg_data;
                CFG_SPIKE_END:      r_cfg.spike_end      <= i_cfg_data;
                CFG_SPIKE_PERIOD:   r_cfg.spike_period   <= i_cfg_data;
                CFG_SPIKE_LEN:      r_cfg.spike_len      <= i_cfg_data;
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    edlr_front u_front (
        .i_tvalid (i_s_axis_tvalid),
        .o_tready (o_s_axis_tready),
        .i_tdata  (i_s_axis_tdata),
        .i_tuser  (i_s_axis_tuser),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_item   (f_item)
    );

    edlr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (f_item),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_count (q_count)
    );

    edlr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .o_tvalid  (o_m_axis_tvalid),
        .i_tready  (i_m_axis_tready),
        .o_tdata   (o_m_axis_tdata)
    );

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_count != '0)
        else $error("back end popped an empty queue");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && !q_pop) |=> q_count == CNT_W'($past(q_count) + 1'b1))
        else $error("queue occupancy did not grow on push");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_pop && !q_push) |=> q_count == CNT_W'($past(q_count) - 1'b1))
        else $error("queue occupancy did not shrink on pop");

endmodule

@@ test/exp_decay_lr_schedule_with_spikes_unit_checker.sv @@
// ----------------------------------------------------------------------------
// exp_decay_lr_schedule_with_spikes_unit_checker
// Watches the config, input and output channels of the schedule unit, keeps a
// shadow of its registers, predicts the rate of every accepted word and
// compares it with the oldest prediction when a rate word is accepted.
// ----------------------------------------------------------------------------
module exp_decay_lr_schedule_with_spikes_unit_checker import edlr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [87:0] i_s_axis_tdata,
    input  logic        i_s_axis_tuser,
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [31:0] i_m_axis_tdata,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_rates_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] RATE_CEIL = 64'hFFFF_FFFF;

    t_cfg        shadow;
    logic [63:0] exp_roots [0:FRAC_BITS];
    logic [31:0] rate_queue [$];

    function automatic logic [63:0] sqrt_floor(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    initial begin
        exp_roots[0] = 64'd1 << 32;
        for (int k = 1; k <= FRAC_BITS; k++)
            exp_roots[k] = sqrt_floor(exp_roots[k-1] << 31);
    end

    // mantissa squaring, one fraction bit per pass, MSB first
    function automatic logic [63:0] log2_fix(input logic [31:0] x);
        int          msb;
        logic [63:0] m;
        logic [63:0] frac;
        msb  = 31;
        frac = '0;
        while (x[msb] == 1'b0) msb--;
        m = 64'(x) << (31 - msb);
        for (int i = FRAC_BITS - 1; i >= 0; i--) begin
            m = (m * m) >> 31;
            if (m >= (64'd2 << 31)) begin
                m = m >> 1;
                frac[i] = 1'b1;
            end
        end
        return (64'(msb) << FRAC_BITS) | frac;
    endfunction

    function automatic logic [63:0] exp2_fix(input logic [63:0] t);
        logic [63:0] acc;
        int          sh;
        acc = 64'd1 << 31;
        for (int k = 1; k <= FRAC_BITS; k++)
            if (t[FRAC_BITS-k]) acc = (acc * exp_roots[k]) >> 31;
        sh  = int'(t[FRAC_BITS+4:FRAC_BITS]);
        acc = (acc << sh) >> 31;
        return (acc > RATE_CEIL) ? RATE_CEIL : acc;
    endfunction

    function automatic logic [63:0] decay_rate(input logic [23:0] it, input logic [31:0] s,
                                               input logic [31:0] f);
        longint      ls;
        longint      lf;
        longint      d;
        longint      t;
        logic [63:0] mag;
        if (it == 0) return 64'(s);
        if (f == 0) return 64'd0;
        ls  = longint'(log2_fix(s));
        lf  = longint'(log2_fix(f));
        d   = lf - ls;
        mag = 64'(d < 0 ? -d : d) * 64'(it) / 64'(shadow.decay_steps);
        t   = (d < 0) ? ls - longint'(mag) : ls + longint'(mag);
        if (t < 0) t = 0;
        if (t > (longint'(32) << FRAC_BITS) - 1) t = (longint'(32) << FRAC_BITS) - 1;
        return exp2_fix(64'(t));
    endfunction

    function automatic logic [31:0] scheduled_rate(input logic [23:0] it,
                                                   input logic [31:0] s,
                                                   input logic [31:0] f,
                                                   input logic spk);
        logic [63:0] base;
        longint      diff;
        logic [63:0] mag;
        longint      fac;
        logic [63:0] off;
        if (it >= shadow.decay_steps) begin
            base = 64'(f);
        end else if (s == 0) begin
            base = '0;
        end else begin
            base = decay_rate(it, s, f);
            if (shadow.delay_steps > 0 && it < shadow.delay_steps) begin
                diff = longint'(ONE_Q16) - longint'(shadow.delay_mult);
                mag  = 64'(diff < 0 ? -diff : diff) * 64'(it) / 64'(shadow.delay_steps);
                fac  = longint'(shadow.delay_mult) +
                       ((diff < 0) ? -longint'(mag) : longint'(mag));
                if (fac < 0) fac = 0;
                base = (base * 64'(fac)) >> 16;
                if (base > RATE_CEIL) base = RATE_CEIL;
            end
        end
        if (spk && it >= shadow.spike_start && it < shadow.spike_end) begin
            off = (shadow.spike_period != 0) ? 64'(it % shadow.spike_period) : 64'(it);
            if (off < 64'(shadow.spike_len)) begin
                base = (64'(s) * (64'(shadow.spike_len) - off) + base * off)
                       / 64'(shadow.spike_len);
                if (base > RATE_CEIL) base = RATE_CEIL;
            end
        end
        return base[31:0];
    endfunction

    assign o_pending = rate_queue.size();

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n) begin
            shadow.delay_mult     <= DELAY_MULT_RST;
            shadow.delay_steps    <= '0;
            shadow.decay_steps    <= DECAY_STEPS_RST;
            shadow.spike_start    <= '0;
            shadow.spike_end      <= '0;
            shadow.spike_period   <= SPIKE_PERIOD_RST;
            shadow.spike_len      <= '0;
            o_fail_count          <= 0;
            o_rates_seen          <= 0;
            rate_queue.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_DELAY_MULT:     shadow.delay_mult     <= i_cfg_data[16:0];
                    CFG_DELAY_STEPS:    shadow.delay_steps    <= i_cfg_data;
                    CFG_DECAY_STEPS:    shadow.decay_steps    <= i_cfg_data;
                    CFG_SPIKE_START:    shadow.spike_start    <= i_cfg_data;
                    CFG_SPIKE_END:      shadow.spike_end      <= i_cfg_data;
                    CFG_SPIKE_PERIOD:   shadow.spike_period   <= i_cfg_data;
                    CFG_SPIKE_LEN:      shadow.spike_len      <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                rate_queue.push_back(scheduled_rate(i_s_axis_tdata[23:0],
                    i_s_axis_tdata[55:24], i_s_axis_tdata[87:56], i_s_axis_tuser));
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                o_rates_seen <= o_rates_seen + 1;
                if (rate_queue.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("unexpected rate word %h", i_m_axis_tdata);
                end else begin
                    want = rate_queue.pop_front();
                    if (want !== i_m_axis_tdata) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10)
                            $display("rate mismatch: expected %h, got %h", want,
                                     i_m_axis_tdata);
                    end
                end
            end
        end
    end

endmodule

@@ test/exp_decay_lr_schedule_with_spikes_unit_tb.sv @@
// ----------------------------------------------------------------------------
// exp_decay_lr_schedule_with_spikes_unit_tb
// Drives the schedule unit through several register settings with directed
// and random words in bursts, a stalling receiver, and a checker beside it.
// ----------------------------------------------------------------------------
module exp_decay_lr_schedule_with_spikes_unit_tb;
    import edlr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_WAIT  = 500;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [87:0] s_data = '0;
    logic        s_user = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    int          rates_seen;
    int          cycles = 0;
    int          burst_left = 0;
    int          words_sent = 0;
    int          settings_run = 0;
    logic [23:0] cur_decay = DECAY_STEPS_RST;
    logic [23:0] cur_delay = '0;
    logic [23:0] cur_spk_lo = '0;
    logic [23:0] cur_spk_hi = '0;

    always #1 i_clk = ~i_clk;

    exp_decay_lr_schedule_with_spikes_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_user),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready), .o_m_axis_tdata(m_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    exp_decay_lr_schedule_with_spikes_unit_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .i_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_user),
        .i_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready), .i_m_axis_tdata(m_data),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_rates_seen(rates_seen)
    );

    // receiver steps through four stall modes, chosen from the cycle counter
    always @(posedge i_clk) begin
        int mode;
        mode = (cycles / 64) % 4;
        case (mode)
            0: m_ready <= 1'b1;
            1: m_ready <= $urandom_range(0, 1);
            2: m_ready <= ($urandom_range(0, 7) == 0);
            default: m_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // valid stays high between writes; program_all drops it after the last one
    task automatic write_reg(input t_cfg_idx idx, input logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        case (idx)
            CFG_DELAY_STEPS: cur_delay  = val;
            CFG_DECAY_STEPS: cur_decay  = val;
            CFG_SPIKE_START: cur_spk_lo = val;
            CFG_SPIKE_END:   cur_spk_hi = val;
            default: ;
        endcase
    endtask

    task automatic send_word(input logic [23:0] it, input logic [31:0] s,
                             input logic [31:0] f, input logic spk);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_valid <= 1'b1;
        s_data  <= {f, s, it};
        s_user  <= spk;
        do @(posedge i_clk); while (!s_ready);
        burst_left--;
        words_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_rate();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1, 255);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [23:0] pick_iter();
        case ($urandom_range(0, 5))
            0: return 24'($urandom);
            1: return (cur_decay == 0) ? 24'd0 : 24'($urandom_range(0, cur_decay - 1));
            2: return (cur_delay == 0) ? 24'($urandom) : 24'($urandom_range(0, cur_delay));
            3: return (cur_spk_hi > cur_spk_lo) ?
                      24'($urandom_range(cur_spk_lo, cur_spk_hi - 1)) : 24'($urandom);
            4: return cur_decay + 24'($urandom_range(0, 3)) - 24'd1;
            default: return 24'($urandom_range(0, 300));
        endcase
    endfunction

    task automatic random_words(input int n);
        repeat (n) send_word(pick_iter(), pick_rate(), pick_rate(), $urandom_range(0, 3) != 0);
    endtask

    task automatic program_all(input logic [23:0] dm, input logic [23:0] dls,
                               input logic [23:0] dcs, input logic [23:0] ss,
                               input logic [23:0] se, input logic [23:0] sp,
                               input logic [23:0] sl);
        write_reg(CFG_DELAY_MULT, dm);
        write_reg(CFG_DELAY_STEPS, dls);
        write_reg(CFG_DECAY_STEPS, dcs);
        write_reg(CFG_SPIKE_START, ss);
        write_reg(CFG_SPIKE_END, se);
        write_reg(CFG_SPIKE_PERIOD, sp);
        write_reg(CFG_SPIKE_LEN, sl);
        cfg_valid <= 1'b0;
        settings_run++;
    endtask

    initial begin
        logic [23:0] r;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: iteration zero, decay reached, zero rates, extremes
        send_word(24'd0, 32'h1000_0000, 32'h0010_0000, 1'b0);
        send_word(24'd1, 32'h1000_0000, 32'h0000_0000, 1'b0);
        send_word(24'd500, 32'h0000_0000, 32'h1234_5678, 1'b0);
        send_word(24'd29999, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1);
        send_word(24'd30000, 32'hFFFF_FFFF, 32'hABCD_EF01, 1'b0);
        send_word(24'hFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1);
        send_word(24'd15000, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
        send_word(24'd15000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        random_words(80);
        drain();

        // warm-up from zero, spikes with wrap
        program_all(24'd0, 24'd2000, 24'd5000, 24'd100, 24'd4000, 24'd50, 24'd20);
        send_word(24'd0, 32'h1000_0000, 32'h0100_0000, 1'b1);
        send_word(24'd100, 32'h1000_0000, 32'h0100_0000, 1'b1);
        send_word(24'd119, 32'h1000_0000, 32'h0100_0000, 1'b1);
        send_word(24'd1999, 32'h1000_0000, 32'h0100_0000, 1'b0);
        send_word(24'd4000, 32'h1000_0000, 32'h0100_0000, 1'b1);
        random_words(150);
        drain();

        // warm-up factor above one, full-range registers, zero spike period
        program_all(24'h1_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'd0, 24'hFF_FFFF, 24'd0,
                    24'hFF_FFFF);
        send_word(24'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_word(24'hFF_FFFE, 32'h8000_0000, 32'h0000_0002, 1'b1);
        random_words(150);
        drain();

        // decay already reached for every iteration
        program_all(24'd65536, 24'd0, 24'd0, 24'd0, 24'd1000, 24'd7, 24'd7);
        send_word(24'd0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
        random_words(100);
        drain();

        // random settings, mostly small
        repeat (4) begin
            r = 24'($urandom_range(1, 20000));
            program_all(24'($urandom_range(0, 65536)), 24'($urandom_range(0, r)), r,
                        24'($urandom_range(0, r)), 24'($urandom_range(0, 2 * r)),
                        24'($urandom_range(0, 200)), 24'($urandom_range(0, 150)));
            random_words(100);
            drain();
        end

        $display("%0d words over %0d register settings, %0d rates checked",
                 words_sent, settings_run + 1, rates_seen);
        $display("covered warm-up, decay end, spike windows and saturating extremes");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
